FILE: design/wspc_pkg.sv
`default_nettype none

package wspc_pkg;

    // input word
    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         motor;
        logic [15:0]        encoder_raw;
        logic signed [15:0] setpoint;
        logic signed [15:0] speed_command;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [1:0]         motor_out;
        logic [1:0]         drive_dir;
        logic               bridge_in1;
        logic               bridge_in2;
        logic [15:0]        duty;
        logic signed [15:0] count_delta;
        logic signed [31:0] position_count;
        logic signed [15:0] measured_speed;
    } out_word_t;

    localparam logic [1:0] ACT_ENCODER = 2'd0;
    localparam logic [1:0] ACT_CONTROL = 2'd1;
    localparam logic [1:0] ACT_DIRECT  = 2'd2;

    localparam logic [1:0] DRV_COAST   = 2'd0;
    localparam logic [1:0] DRV_FWD     = 2'd1;
    localparam logic [1:0] DRV_REV     = 2'd2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIR_SIGNS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DUTY_GAIN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_SCALE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROP_GAIN   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDFORWARD = 3'd7;

    localparam logic [2:0]  RST_DIR_SIGNS   = 3'd0;
    localparam logic [14:0] RST_MAX_SPEED   = 15'd4096;
    localparam logic [11:0] RST_DEADBAND    = 12'd4;
    localparam logic [15:0] RST_PWM_PERIOD  = 16'd3599;
    localparam logic [15:0] RST_DUTY_GAIN   = 16'd3599;
    localparam logic [23:0] RST_SPEED_SCALE = 24'd0;
    localparam logic [15:0] RST_PROP_GAIN   = 16'd256;
    localparam logic [15:0] RST_FEEDFORWARD = 16'd0;

    // bit-serial multiplier: signed multiplicand, unsigned multiplier
    localparam int MCAND_W   = 17;
    localparam int MPLIER_W  = 24;
    localparam int ACC_W     = MCAND_W + 1;
    localparam int PROD_W    = ACC_W + MPLIER_W;
    localparam int MUL_CNT_W = $clog2(MPLIER_W);

endpackage

`default_nettype wire

FILE: design/wheel_speed_p_controller_core.sv
// States after PREP: encoder sample MUL, RND, FIN, OUT; control step MUL, RND, FIN,
// DRV, DIR, MUL, DUTY, OUT; direct command DRV, DIR, MUL, DUTY, OUT; unknown action
// or absent motor straight to OUT. Each multiply runs through one shared radix-2
// shift-add unit. One word in flight; the next word can be taken once its result is
// registered, while that result may still wait on m_ready.
// Synchronous active-low reset restores register defaults and zeroes all motor state.
`default_nettype none

module wheel_speed_p_controller_core
    import wspc_pkg::*;
#(
    parameter int MOTORS = 3
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_word_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_word_t                   m_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic [3:0] MOTORS_C = 4'(MOTORS);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PREP = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_RND  = 4'd3;
    localparam logic [3:0] ST_FIN  = 4'd4;
    localparam logic [3:0] ST_DRV  = 4'd5;
    localparam logic [3:0] ST_DIR  = 4'd6;
    localparam logic [3:0] ST_DUTY = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    localparam logic [1:0] OP_SPEED = 2'd0;
    localparam logic [1:0] OP_CTRL  = 2'd1;
    localparam logic [1:0] OP_DUTY  = 2'd2;

    localparam logic [PROD_W-1:0] RND_SPEED = PROD_W'(32768);
    localparam logic [PROD_W-1:0] RND_CTRL  = PROD_W'(128);

    function automatic logic signed [15:0] sat16(input logic signed [26:0] x);
        if (x > 27'sd32767) begin
            return 16'sh7fff;
        end else if (x < -27'sd32768) begin
            return 16'sh8000;
        end else begin
            return x[15:0];
        end
    endfunction

    // configuration
    logic [2:0]  dir_signs_reg, dir_signs_next;
    logic [14:0] max_speed_reg, max_speed_next;
    logic [11:0] deadband_reg, deadband_next;
    logic [15:0] pwm_period_reg, pwm_period_next;
    logic [15:0] duty_gain_reg, duty_gain_next;
    logic [23:0] speed_scale_reg, speed_scale_next;
    logic [15:0] prop_gain_reg, prop_gain_next;
    logic [15:0] feedforward_reg, feedforward_next;

    // per-motor state
    logic [15:0] prev_counter_reg [MOTORS];
    logic [15:0] prev_counter_next [MOTORS];
    logic [31:0] position_reg [MOTORS];
    logic [31:0] position_next [MOTORS];
    logic [15:0] last_delta_reg [MOTORS];
    logic [15:0] last_delta_next [MOTORS];
    logic [15:0] speed_meas_reg [MOTORS];
    logic [15:0] speed_meas_next [MOTORS];
    logic [1:0]  drive_state_reg [MOTORS];
    logic [1:0]  drive_state_next [MOTORS];
    logic [15:0] duty_state_reg [MOTORS];
    logic [15:0] duty_state_next [MOTORS];

    // control
    logic [3:0]  state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // datapath
    in_word_t                  in_reg, in_next;
    logic [1:0]                op_reg, op_next;
    logic signed [ACC_W-1:0]   mul_hi_reg, mul_hi_next;
    logic [MPLIER_W-1:0]       mul_lo_reg, mul_lo_next;
    logic signed [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [MUL_CNT_W-1:0]      mul_cnt_reg, mul_cnt_next;
    logic signed [25:0]        rnd_reg, rnd_next;
    logic signed [15:0]        v_reg, v_next;
    out_word_t                 m_data_reg, m_data_next;

    // comb temporaries
    logic [2:0]              motor_ext;
    logic [MIDX_W-1:0]       idx;
    logic                    in_range;
    logic                    sign_bit;
    logic [3:0]              signs_ext;
    logic [15:0]             delta;
    logic signed [ACC_W-1:0] mul_sum;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-1:0]       rsum;
    logic signed [26:0]      ctl_sum;
    logic signed [16:0]      v17;
    logic signed [16:0]      vneg;
    logic signed [16:0]      lim17;
    logic signed [16:0]      db17;
    logic [15:0]             mag;
    logic [19:0]             dq;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign motor_ext = {1'b0, in_reg.motor};
    assign idx       = motor_ext[MIDX_W-1:0];
    assign in_range  = ({1'b0, motor_ext} < MOTORS_C);
    assign signs_ext = {1'b0, dir_signs_reg};
    assign sign_bit  = signs_ext[in_reg.motor];
    assign prod      = {mul_hi_reg, mul_lo_reg};

    always_comb begin
        dir_signs_next   = dir_signs_reg;
        max_speed_next   = max_speed_reg;
        deadband_next    = deadband_reg;
        pwm_period_next  = pwm_period_reg;
        duty_gain_next   = duty_gain_reg;
        speed_scale_next = speed_scale_reg;
        prop_gain_next   = prop_gain_reg;
        feedforward_next = feedforward_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_DIR_SIGNS:   dir_signs_next   = cfg_data[2:0];
                CFG_MAX_SPEED:   max_speed_next   = cfg_data[14:0];
                CFG_DEADBAND:    deadband_next    = cfg_data[11:0];
                CFG_PWM_PERIOD:  pwm_period_next  = cfg_data[15:0];
                CFG_DUTY_GAIN:   duty_gain_next   = cfg_data[15:0];
                CFG_SPEED_SCALE: speed_scale_next = cfg_data[23:0];
                CFG_PROP_GAIN:   prop_gain_next   = cfg_data[15:0];
                CFG_FEEDFORWARD: feedforward_next = cfg_data[15:0];
            endcase
        end
    end

    always_comb begin
        prev_counter_next = prev_counter_reg;
        position_next     = position_reg;
        last_delta_next   = last_delta_reg;
        speed_meas_next   = speed_meas_reg;
        drive_state_next  = drive_state_reg;
        duty_state_next   = duty_state_reg;
        state_next        = state_reg;
        m_valid_next      = m_valid_reg;
        in_next           = in_reg;
        op_next           = op_reg;
        mul_hi_next       = mul_hi_reg;
        mul_lo_next       = mul_lo_reg;
        mcand_next        = mcand_reg;
        mul_cnt_next      = mul_cnt_reg;
        rnd_next          = rnd_reg;
        v_next            = v_reg;
        m_data_next       = m_data_reg;

        delta   = in_reg.encoder_raw - prev_counter_reg[idx];
        mul_sum = mul_hi_reg + (mul_lo_reg[0] ? ACC_W'(mcand_reg) : ACC_W'(0));
        rsum    = prod + ((op_reg == OP_SPEED) ? RND_SPEED : RND_CTRL);
        ctl_sum = {rnd_reg[25], rnd_reg} + {{11{feedforward_reg[15]}}, feedforward_reg};
        v17     = {v_reg[15], v_reg};
        vneg    = sign_bit ? -v17 : v17;
        lim17   = {2'b00, max_speed_reg};
        db17    = {5'b00000, deadband_reg};
        mag     = v_reg[15] ? 16'(-v_reg) : v_reg;
        dq      = prod[31:12];

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                mul_hi_next  = '0;
                mul_cnt_next = MUL_CNT_W'(MPLIER_W - 1);
                if (!in_range) begin
                    state_next = ST_OUT;
                end else begin
                    unique case (in_reg.action)
                        ACT_ENCODER: begin
                            prev_counter_next[idx] = in_reg.encoder_raw;
                            last_delta_next[idx]   = delta;
                            position_next[idx]     = position_reg[idx] +
                                                     {{16{delta[15]}}, delta};
                            mcand_next  = {delta[15], delta};
                            mul_lo_next = speed_scale_reg;
                            op_next     = OP_SPEED;
                            state_next  = ST_MUL;
                        end
                        ACT_CONTROL: begin
                            mcand_next  = {in_reg.setpoint[15], in_reg.setpoint} -
                                          {speed_meas_reg[idx][15], speed_meas_reg[idx]};
                            mul_lo_next = {8'h00, prop_gain_reg};
                            op_next     = OP_CTRL;
                            state_next  = ST_MUL;
                        end
                        ACT_DIRECT: begin
                            v_next     = in_reg.speed_command;
                            state_next = ST_DRV;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_MUL: begin
                mul_hi_next  = {mul_sum[ACC_W-1], mul_sum[ACC_W-1:1]};
                mul_lo_next  = {mul_sum[0], mul_lo_reg[MPLIER_W-1:1]};
                mul_cnt_next = mul_cnt_reg - 1'b1;
                if (mul_cnt_reg == '0) begin
                    state_next = (op_reg == OP_DUTY) ? ST_DUTY : ST_RND;
                end
            end
            ST_RND: begin
                rnd_next   = (op_reg == OP_SPEED) ? rsum[41:16] : rsum[33:8];
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (op_reg == OP_SPEED) begin
                    speed_meas_next[idx] = sat16({rnd_reg[25], rnd_reg});
                    state_next           = ST_OUT;
                end else begin
                    v_next     = sat16(ctl_sum);
                    state_next = ST_DRV;
                end
            end
            ST_DRV: begin
                // direction sign, then clamp to +-max_speed
                if (vneg > lim17) begin
                    v_next = lim17[15:0];
                end else if (vneg < -lim17) begin
                    v_next = 16'(-lim17);
                end else begin
                    v_next = vneg[15:0];
                end
                state_next = ST_DIR;
            end
            ST_DIR: begin
                if (v17 > db17) begin
                    drive_state_next[idx] = DRV_FWD;
                end else if (v17 < -db17) begin
                    drive_state_next[idx] = DRV_REV;
                end else begin
                    drive_state_next[idx] = DRV_COAST;
                end
                mcand_next   = {1'b0, mag};
                mul_lo_next  = {8'h00, duty_gain_reg};
                mul_hi_next  = '0;
                mul_cnt_next = MUL_CNT_W'(MPLIER_W - 1);
                op_next      = OP_DUTY;
                state_next   = ST_MUL;
            end
            ST_DUTY: begin
                duty_state_next[idx] = (dq > {4'h0, pwm_period_reg}) ? pwm_period_reg :
                                                                       dq[15:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next           = '0;
                    m_data_next.motor_out = in_reg.motor;
                    if (in_range) begin
                        m_data_next.drive_dir      = drive_state_reg[idx];
                        m_data_next.bridge_in1     = (drive_state_reg[idx] == DRV_FWD);
                        m_data_next.bridge_in2     = (drive_state_reg[idx] == DRV_REV);
                        m_data_next.duty           = duty_state_reg[idx];
                        m_data_next.count_delta    = last_delta_reg[idx];
                        m_data_next.position_count = position_reg[idx];
                        m_data_next.measured_speed = speed_meas_reg[idx];
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_signs_reg   <= RST_DIR_SIGNS;
            max_speed_reg   <= RST_MAX_SPEED;
            deadband_reg    <= RST_DEADBAND;
            pwm_period_reg  <= RST_PWM_PERIOD;
            duty_gain_reg   <= RST_DUTY_GAIN;
            speed_scale_reg <= RST_SPEED_SCALE;
            prop_gain_reg   <= RST_PROP_GAIN;
            feedforward_reg <= RST_FEEDFORWARD;
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            for (int i = 0; i < MOTORS; i++) begin
                prev_counter_reg[i] <= '0;
                position_reg[i]     <= '0;
                last_delta_reg[i]   <= '0;
                speed_meas_reg[i]   <= '0;
                drive_state_reg[i]  <= DRV_COAST;
                duty_state_reg[i]   <= '0;
            end
        end else begin
            dir_signs_reg    <= dir_signs_next;
            max_speed_reg    <= max_speed_next;
            deadband_reg     <= deadband_next;
            pwm_period_reg   <= pwm_period_next;
            duty_gain_reg    <= duty_gain_next;
            speed_scale_reg  <= speed_scale_next;
            prop_gain_reg    <= prop_gain_next;
            feedforward_reg  <= feedforward_next;
            state_reg        <= state_next;
            m_valid_reg      <= m_valid_next;
            prev_counter_reg <= prev_counter_next;
            position_reg     <= position_next;
            last_delta_reg   <= last_delta_next;
            speed_meas_reg   <= speed_meas_next;
            drive_state_reg  <= drive_state_next;
            duty_state_reg   <= duty_state_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        op_reg      <= op_next;
        mul_hi_reg  <= mul_hi_next;
        mul_lo_reg  <= mul_lo_next;
        mcand_reg   <= mcand_next;
        mul_cnt_reg <= mul_cnt_next;
        rnd_reg     <= rnd_next;
        v_reg       <= v_next;
        m_data_reg  <= m_data_next;
    end

    // one word at a time
    a_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word taken while one is in flight");

    a_result_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && (!m_valid_reg || m_ready)
        |=> m_valid && m_data.motor_out == in_reg.motor)
        else $error("result does not belong to the word in flight");

    a_bridge_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.bridge_in1 && m_data.bridge_in2))
        else $error("both bridge inputs high");

    a_bridge_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.bridge_in1 == (m_data.drive_dir == DRV_FWD)) &&
                    (m_data.bridge_in2 == (m_data.drive_dir == DRV_REV)))
        else $error("bridge levels disagree with drive direction");

    a_absent_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !({2'b00, m_data.motor_out} < MOTORS_C)
        |-> m_data.duty == '0 && m_data.position_count == '0 &&
            m_data.drive_dir == DRV_COAST)
        else $error("absent motor reported non-zero state");

endmodule

`default_nettype wire

FILE: tb/wheel_speed_p_controller_core_test.sv
`timescale 1ns / 1ps

module wheel_speed_p_controller_core_test;
    import wspc_pkg::*;

    localparam int MOTORS          = 3;
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 160;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 64;

    localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
    localparam logic [1:0] MOTOR_ABSENT = 2'(MOTORS);

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_word_t               s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_word_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DIR_SIGNS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    wheel_speed_p_controller_core #(.MOTORS(MOTORS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // register shadow
    logic [2:0]         sign_mask   = RST_DIR_SIGNS;
    logic [14:0]        speed_limit = RST_MAX_SPEED;
    logic [11:0]        dead_zone   = RST_DEADBAND;
    logic [15:0]        pwm_top     = RST_PWM_PERIOD;
    logic [15:0]        duty_scale  = RST_DUTY_GAIN;
    logic [23:0]        enc_scale   = RST_SPEED_SCALE;
    logic [15:0]        kp_gain     = RST_PROP_GAIN;
    logic signed [15:0] ff_offset   = RST_FEEDFORWARD;

    // per-motor state as the block should hold it
    logic [15:0]        prev_q  [MOTORS];
    logic [31:0]        pos_q   [MOTORS];
    logic signed [15:0] delta_q [MOTORS];
    logic signed [15:0] speed_q [MOTORS];
    logic [1:0]         dir_q   [MOTORS];
    logic [15:0]        duty_q  [MOTORS];

    logic [15:0]        raw_track [MOTORS];

    in_word_t    motor_commands[$];
    out_word_t   predicted_status[$];
    int unsigned words_sent  = 0;
    int unsigned words_taken = 0;
    int          fail_count  = 0;
    int unsigned cycle_count = 0;

    int          burst_left  = 1;
    int          gap_left    = 0;
    logic [15:0] ready_pat   = 16'hffff;
    int unsigned ready_tick  = 0;

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // floor((p + 2^(s-1)) / 2^s)
    function automatic longint round_half_up(input longint p, input int s);
        return (p + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void apply_drive(input int m, input longint v);
        longint lim, dz, mag, d;
        lim = longint'(speed_limit);
        dz  = longint'(dead_zone);
        if (sign_mask[m]) v = -v;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        if (v > dz) dir_q[m] = DRV_FWD;
        else if (v < -dz) dir_q[m] = DRV_REV;
        else dir_q[m] = DRV_COAST;
        mag = (v < 0) ? -v : v;
        d = (mag * longint'(duty_scale)) >>> 12;
        if (d > longint'(pwm_top)) d = longint'(pwm_top);
        duty_q[m] = d[15:0];
    endfunction

    function automatic out_word_t wheel_response(input in_word_t w);
        out_word_t   r;
        int          m;
        logic [15:0] diff;
        longint      d, err, o;
        r = '0;
        r.motor_out = w.motor;
        m = int'(w.motor);
        if (m >= MOTORS) return r;
        case (w.action)
            ACT_ENCODER: begin
                diff = w.encoder_raw - prev_q[m];
                d = longint'($signed(diff));
                prev_q[m]  = w.encoder_raw;
                pos_q[m]   = pos_q[m] + d[31:0];
                delta_q[m] = diff;
                speed_q[m] = sat16(round_half_up(d * longint'(enc_scale), 16));
            end
            ACT_CONTROL: begin
                err = longint'($signed(w.setpoint)) - longint'(speed_q[m]);
                o = round_half_up(longint'(kp_gain) * err, 8) + longint'(ff_offset);
                apply_drive(m, longint'(sat16(o)));
            end
            ACT_DIRECT: begin
                apply_drive(m, longint'($signed(w.speed_command)));
            end
            default: ;
        endcase
        r.drive_dir      = dir_q[m];
        r.bridge_in1     = (dir_q[m] == DRV_FWD);
        r.bridge_in2     = (dir_q[m] == DRV_REV);
        r.duty           = duty_q[m];
        r.count_delta    = delta_q[m];
        r.position_count = pos_q[m];
        r.measured_speed = speed_q[m];
        return r;
    endfunction

    function automatic logic [31:0] rand_mag(input int w);
        int n;
        n = $urandom_range(1, w);
        return $urandom & ((32'd1 << n) - 1);
    endfunction

    // encoder, control and direct words, encoder runs with plausible steps, a few absent motors and unknown actions
    function automatic in_word_t make_item();
        in_word_t    w;
        int unsigned roll;
        w.encoder_raw   = 16'($urandom);
        w.setpoint      = 16'($urandom);
        w.speed_command = 16'($urandom);
        w.motor = ($urandom_range(0, 99) < 4) ? MOTOR_ABSENT
                                              : 2'($urandom_range(0, MOTORS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 3) w.action = ACT_UNKNOWN;
        else if (roll < 45) w.action = ACT_ENCODER;
        else if (roll < 80) w.action = ACT_CONTROL;
        else w.action = ACT_DIRECT;
        roll = $urandom_range(0, 99);
        if (w.action == ACT_ENCODER && w.motor < MOTORS) begin
            if (roll < 85)
                w.encoder_raw = 16'(int'(raw_track[w.motor]) + int'($urandom_range(0, 600)) - 300);
            raw_track[w.motor] = w.encoder_raw;
        end
        if (roll < 50) begin
            w.setpoint      = 16'(int'($urandom_range(0, 8192)) - 4096);
            w.speed_command = 16'(int'($urandom_range(0, 8192)) - 4096);
        end
        return w;
    endfunction

    task automatic queue_word(input logic [1:0] act, input logic [1:0] mot,
                              input logic [15:0] raw, input logic [15:0] tgt,
                              input logic [15:0] cmd);
        in_word_t w;
        w.action        = act;
        w.motor         = mot;
        w.encoder_raw   = raw;
        w.setpoint      = tgt;
        w.speed_command = cmd;
        motor_commands.push_back(w);
        words_sent++;
    endtask

    task automatic wait_idle();
        while (words_taken != words_sent || predicted_status.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DIR_SIGNS:   sign_mask   = val[2:0];
            CFG_MAX_SPEED:   speed_limit = val[14:0];
            CFG_DEADBAND:    dead_zone   = val[11:0];
            CFG_PWM_PERIOD:  pwm_top     = val[15:0];
            CFG_DUTY_GAIN:   duty_scale  = val[15:0];
            CFG_SPEED_SCALE: enc_scale   = val[23:0];
            CFG_PROP_GAIN:   kp_gain     = val[15:0];
            CFG_FEEDFORWARD: ff_offset   = val[15:0];
        endcase
    endtask

    task automatic load_settings(input logic [2:0] signs, input logic [14:0] vmax,
                                 input logic [11:0] dz, input logic [15:0] top,
                                 input logic [15:0] dg, input logic [23:0] sc,
                                 input logic [15:0] kp, input logic [15:0] ff);
        write_reg(CFG_DIR_SIGNS,   {21'd0, signs});
        write_reg(CFG_MAX_SPEED,   {9'd0, vmax});
        write_reg(CFG_DEADBAND,    {12'd0, dz});
        write_reg(CFG_PWM_PERIOD,  {8'd0, top});
        write_reg(CFG_DUTY_GAIN,   {8'd0, dg});
        write_reg(CFG_SPEED_SCALE, sc);
        write_reg(CFG_PROP_GAIN,   {8'd0, kp});
        write_reg(CFG_FEEDFORWARD, {8'd0, ff});
        cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_status(input out_word_t want, input out_word_t got);
        compare_field("motor_out",      want.motor_out,      got.motor_out);
        compare_field("drive_dir",      want.drive_dir,      got.drive_dir);
        compare_field("bridge_in1",     want.bridge_in1,     got.bridge_in1);
        compare_field("bridge_in2",     want.bridge_in2,     got.bridge_in2);
        compare_field("duty",           want.duty,           got.duty);
        compare_field("count_delta",    want.count_delta,    got.count_delta);
        compare_field("position_count", want.position_count, got.position_count);
        compare_field("measured_speed", want.measured_speed, got.measured_speed);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted_status.push_back(wheel_response(s_data));
                words_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (motor_commands.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= motor_commands.pop_front();
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall pattern on m_ready, re-chosen now and then, sometimes none at all
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_status.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none actual %h", $time, m_data);
                end else begin
                    check_status(predicted_status.pop_front(), m_data);
                end
            end
            ready_tick++;
            if (ready_tick % 200 == 0)
                ready_pat = ($urandom_range(0, 3) == 0) ? 16'hffff
                          : 16'($urandom) | (16'd1 << $urandom_range(0, 15));
            m_ready <= ready_pat[ready_tick % 16];
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] ff_pick;
        for (int i = 0; i < MOTORS; i++) begin
            prev_q[i]    = '0;
            pos_q[i]     = '0;
            delta_q[i]   = '0;
            speed_q[i]   = '0;
            dir_q[i]     = DRV_COAST;
            duty_q[i]    = '0;
            raw_track[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: delta wrap both ways, clamp, deadband, stop
        queue_word(ACT_ENCODER, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_word(ACT_ENCODER, 2'd0, 16'h7fff, 16'h0000, 16'h0000);
        queue_word(ACT_ENCODER, 2'd0, 16'hffff, 16'h0000, 16'h0000);
        queue_word(ACT_ENCODER, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_word(ACT_DIRECT,  2'd1, 16'h0000, 16'h0000, 16'h7fff);
        queue_word(ACT_DIRECT,  2'd1, 16'h0000, 16'h0000, 16'h8000);
        queue_word(ACT_DIRECT,  2'd1, 16'h0000, 16'h0000, 16'h0004);
        queue_word(ACT_DIRECT,  2'd1, 16'h0000, 16'h0000, 16'h0000);
        queue_word(ACT_CONTROL, 2'd2, 16'h0000, 16'h7fff, 16'h0000);
        queue_word(ACT_CONTROL, 2'd2, 16'h0000, 16'h8000, 16'h0000);
        queue_word(ACT_UNKNOWN, 2'd0, 16'hffff, 16'hffff, 16'hffff);
        queue_word(ACT_ENCODER, MOTOR_ABSENT, 16'hffff, 16'h0000, 16'h0000);
        wait_idle();

        // full-scale gains, negated motors 0 and 2, saturating speeds and products
        load_settings(3'b101, 15'h7fff, 12'd0, 16'hffff, 16'hffff, 24'hffffff,
                      16'hffff, 16'h8000);
        queue_word(ACT_ENCODER, 2'd0, 16'h8000, 16'h0000, 16'h0000);
        queue_word(ACT_ENCODER, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_word(ACT_ENCODER, 2'd1, 16'h0001, 16'h0000, 16'h0000);
        queue_word(ACT_CONTROL, 2'd0, 16'h0000, 16'h7fff, 16'h0000);
        queue_word(ACT_CONTROL, 2'd1, 16'h0000, 16'h8000, 16'h0000);
        queue_word(ACT_DIRECT,  2'd2, 16'h0000, 16'h0000, 16'h8000);
        queue_word(ACT_DIRECT,  2'd0, 16'h0000, 16'h0000, 16'h7fff);
        queue_word(ACT_DIRECT,  MOTOR_ABSENT, 16'h0000, 16'h0000, 16'h0064);
        queue_word(ACT_CONTROL, MOTOR_ABSENT, 16'h0000, 16'h1000, 16'h0000);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                load_settings(3'b111, 15'h7fff, 12'hfff, 16'hffff, 16'hffff, 24'hffffff,
                              16'hffff, 16'h7fff);
            end else if (p == 1) begin
                // zero clamp and zero period: everything coasts at duty 0
                load_settings(3'b000, 15'd0, 12'd0, 16'd0, 16'd0, 24'd0, 16'd0, 16'h8000);
            end else if (p == 2) begin
                load_settings(3'b010, 15'd1, 12'd0, 16'd1, 16'd1, 24'd1, 16'd1, 16'h0000);
            end else begin
                ff_pick = $urandom_range(0, 1) ? 16'(rand_mag(14)) : -16'(rand_mag(14));
                load_settings(3'($urandom_range(0, 7)), 15'(rand_mag(15)),
                              12'(rand_mag(12)), 16'(rand_mag(16)), 16'(rand_mag(16)),
                              24'(rand_mag(24)), 16'(rand_mag(16)), ff_pick);
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                motor_commands.push_back(make_item());
                words_sent++;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && predicted_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
